// ===== rtl/ewca_pkg.sv =====
`timescale 1ns / 1ps

package ewca_pkg;

  localparam int MAX_MULT    = 64;
  localparam int ENERGY_BITS = 16;

  localparam int ENERGY_W = 16;
  localparam int ESUM_W   = 22;
  localparam int WSUM_W   = 38;
  localparam int WORD_W   = 16;
  localparam int ID_W     = 12;
  localparam int PID_W    = 13;
  localparam int CNT_W    = 7;

  localparam int NUM_SUMS = 5;
  localparam int SEL_W    = $clog2(NUM_SUMS);
  localparam int PROD_W   = ENERGY_W + 1 + WORD_W;

  // quotient bits kept by the divider, two retired per step
  localparam int QUOT_W    = 18;
  localparam int DIV_STEPS = QUOT_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int NUM_W     = WSUM_W + 1;

  typedef logic        [ENERGY_W-1:0] energy_t;
  typedef logic        [ESUM_W-1:0]   esum_t;
  typedef logic signed [WSUM_W-1:0]   wsum_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic        [ID_W-1:0]     id_t;
  typedef logic signed [PID_W-1:0]    pid_t;
  typedef logic        [CNT_W-1:0]    count_t;
  typedef logic        [SEL_W-1:0]    sel_t;

  localparam energy_t ENERGY_MASK = ENERGY_W'((64'd1 << ENERGY_BITS) - 64'd1);
  localparam count_t  CAP_LIMIT   = CNT_W'(MAX_MULT);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam sel_t SUM_X    = SEL_W'(0);
  localparam sel_t SUM_Y    = SEL_W'(1);
  localparam sel_t SUM_ADC  = SEL_W'(2);
  localparam sel_t SUM_TDC  = SEL_W'(3);
  localparam sel_t SUM_WALK = SEL_W'(4);

  localparam pid_t  PEAK_ID_NONE = -PID_W'(1);
  localparam esum_t ESUM_MAX     = '1;
  localparam word_t MEAN_MAX     = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t MEAN_MIN     = {1'b1, {(WORD_W-1){1'b0}}};

endpackage

// ===== rtl/ewca_if.sv =====
`timescale 1ns / 1ps

interface ewca_hit_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  ewca_pkg::energy_t   block_energy;
  ewca_pkg::word_t     block_x;
  ewca_pkg::word_t     block_y;
  ewca_pkg::word_t     adc_time;
  ewca_pkg::id_t       element_id;
  logic                has_tdc;
  ewca_pkg::word_t     tdc_time;
  ewca_pkg::word_t     tdc_time_walk;

  modport source (
    output valid, opcode, block_energy, block_x, block_y, adc_time, element_id,
           has_tdc, tdc_time, tdc_time_walk,
    input  ready
  );
  modport sink (
    input  valid, opcode, block_energy, block_x, block_y, adc_time, element_id,
           has_tdc, tdc_time, tdc_time_walk,
    output ready
  );
endinterface

interface ewca_sum_if;
  logic                valid;
  logic                ready;
  logic                accepted;
  ewca_pkg::count_t    multiplicity;
  ewca_pkg::esum_t     energy_total;
  ewca_pkg::energy_t   max_block_energy;
  ewca_pkg::pid_t      max_block_id;
  ewca_pkg::word_t     centroid_x;
  ewca_pkg::word_t     centroid_y;
  ewca_pkg::word_t     adc_time_mean;
  ewca_pkg::word_t     tdc_time_mean;
  ewca_pkg::word_t     tdc_walk_mean;
  ewca_pkg::word_t     tdc_time_of_max;
  ewca_pkg::count_t    good_tdc_count;

  modport source (
    output valid, accepted, multiplicity, energy_total, max_block_energy,
           max_block_id, centroid_x, centroid_y, adc_time_mean, tdc_time_mean,
           tdc_walk_mean, tdc_time_of_max, good_tdc_count,
    input  ready
  );
  modport sink (
    input  valid, accepted, multiplicity, energy_total, max_block_energy,
           max_block_id, centroid_x, centroid_y, adc_time_mean, tdc_time_mean,
           tdc_walk_mean, tdc_time_of_max, good_tdc_count,
    output ready
  );
endinterface

// ===== rtl/ewca_mac.sv =====
`timescale 1ns / 1ps

// Shared multiplier with a saturating accumulate behind its product register.
module ewca_mac (
  input  logic              clk,
  input  logic              mul_en,
  input  ewca_pkg::energy_t energy,
  input  ewca_pkg::word_t   operand,
  input  ewca_pkg::wsum_t   acc,
  output ewca_pkg::wsum_t   sum
);

  logic signed [ewca_pkg::ENERGY_W:0]      energy_s;
  logic signed [ewca_pkg::PROD_W-1:0]      prod;
  logic signed [ewca_pkg::WSUM_W:0]        total;

  assign energy_s = {1'b0, energy};

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= energy_s * operand;
    end
  end

  assign total = (ewca_pkg::WSUM_W + 1)'(acc) + (ewca_pkg::WSUM_W + 1)'(prod);

  always_comb begin
    case (total[ewca_pkg::WSUM_W -: 2])
      2'b01:   sum = {1'b0, {(ewca_pkg::WSUM_W-1){1'b1}}};
      2'b10:   sum = {1'b1, {(ewca_pkg::WSUM_W-1){1'b0}}};
      default: sum = total[ewca_pkg::WSUM_W-1:0];
    endcase
  end

endmodule

// ===== rtl/ewca_div.sv =====
`timescale 1ns / 1ps

// Rounded, clamped mean = sum / den. Radix-4 restoring division, one cycle per
// two quotient bits; a zero divisor or a quotient too large for 18 bits is
// settled at load.
module ewca_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ewca_pkg::wsum_t sum,
  input  ewca_pkg::esum_t den,
  output logic            done,
  output ewca_pkg::word_t mean
);

  localparam int RW = ewca_pkg::ESUM_W;
  localparam int QW = ewca_pkg::QUOT_W;
  localparam int NW = ewca_pkg::NUM_W;

  logic                            busy;
  logic [ewca_pkg::DIV_CNT_W-1:0]  cnt;
  logic                            neg;
  logic                            zero;
  logic                            ovf;
  ewca_pkg::esum_t                 divisor;
  logic [RW-1:0]                   rem;
  logic [QW-1:0]                   low;
  logic [QW-1:0]                   quot;

  logic [ewca_pkg::WSUM_W-1:0]     mag;
  logic [NW-1:0]                   num;
  logic [RW:0]                     num_hi;
  logic [RW:0]                     t1, t2;
  logic                            ge1, ge2;
  logic [RW-1:0]                   r1, r2;
  logic [QW-1:0]                   limit;

  // magnitude plus half the divisor gives round-half-away on the quotient
  assign mag    = sum[ewca_pkg::WSUM_W-1] ? ewca_pkg::WSUM_W'(-sum)
                                          : ewca_pkg::WSUM_W'(sum);
  assign num    = {1'b0, mag} + NW'(den >> 1);
  assign num_hi = (RW + 1)'(num[NW-1:QW]);

  assign t1  = {rem, low[QW-1]};
  assign ge1 = t1 >= {1'b0, divisor};
  assign r1  = ge1 ? RW'(t1 - {1'b0, divisor}) : t1[RW-1:0];
  assign t2  = {r1, low[QW-2]};
  assign ge2 = t2 >= {1'b0, divisor};
  assign r2  = ge2 ? RW'(t2 - {1'b0, divisor}) : t2[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg     <= sum[ewca_pkg::WSUM_W-1];
        zero    <= (den == '0);
        ovf     <= (num_hi >= {1'b0, den});
        divisor <= den;
        rem     <= num_hi[RW-1:0];
        low     <= num[QW-1:0];
        quot    <= '0;
        cnt     <= '0;
        busy    <= !((den == '0) || (num_hi >= {1'b0, den}));
        done    <= (den == '0) || (num_hi >= {1'b0, den});
      end else if (busy) begin
        rem  <= r2;
        low  <= {low[QW-3:0], 2'b00};
        quot <= {quot[QW-3:0], ge1, ge2};
        cnt  <= cnt + 1'b1;
        if (cnt == ewca_pkg::DIV_CNT_W'(ewca_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign limit = neg ? QW'(32768) : QW'(32767);

  always_comb begin
    if (zero) begin
      mean = '0;
    end else if (ovf || (quot > limit)) begin
      mean = neg ? ewca_pkg::MEAN_MIN : ewca_pkg::MEAN_MAX;
    end else if (neg) begin
      mean = -quot[ewca_pkg::WORD_W-1:0];
    end else begin
      mean = quot[ewca_pkg::WORD_W-1:0];
    end
  end

endmodule

// ===== rtl/energy_weighted_cluster_accumulator.sv =====
// Energy-weighted cluster accumulator.
// hit: one calorimeter block per transfer (valid/ready). opcode add puts the
//   block into the cluster while its multiplicity is below min(max_elements,
//   64); opcode clear empties the cluster.
// summary: one result per hit transfer, carrying the cluster summary after it.
// cfg_we/cfg_wdata: writes max_elements (reset value 9); the user writes it
//   only while the block idles, which the block itself does not enforce.
// Sequencing: hit.ready is high only while the sequencer is idle. A dropped
//   block or a clear goes from S_IDLE straight to S_FINISH. An accepted block
//   runs the shared multiplier once per weighted sum (S_MUL, S_ADD), then the
//   shared divider once per mean (S_DIV_GO, S_DIV_WAIT), which settles a zero
//   divisor or saturated quotient at load; three sums without TDC data, five
//   with it. The next hit can be taken in the cycle after a summary is loaded.
// The summary register holds its result until taken; a finished item waits in
//   the last sequencer state while summary is stalled, and a new hit is taken
//   while the previous summary is still waiting.
// Reset (rst, synchronous) empties the cluster, drops any pending summary and
//   restores max_elements to 9.
`timescale 1ns / 1ps

module energy_weighted_cluster_accumulator (
  input  logic         clk,
  input  logic         rst,
  ewca_hit_if.sink     hit,
  ewca_sum_if.source   summary,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MUL,
    S_ADD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  state_t                  state;
  ewca_pkg::count_t        max_elements;
  ewca_pkg::count_t        cap;
  ewca_pkg::sel_t          sel;
  ewca_pkg::sel_t          last_sel;
  logic                    accepted;

  // captured block
  ewca_pkg::energy_t       blk_e;
  ewca_pkg::word_t         blk_x;
  ewca_pkg::word_t         blk_y;
  ewca_pkg::word_t         blk_adc;
  ewca_pkg::id_t           blk_id;
  logic                    blk_has_tdc;
  ewca_pkg::word_t         blk_tdc;
  ewca_pkg::word_t         blk_walk;

  // cluster state
  ewca_pkg::count_t        block_count;
  ewca_pkg::esum_t         energy_sum;
  ewca_pkg::wsum_t         wsum [ewca_pkg::NUM_SUMS];
  ewca_pkg::word_t         mean [ewca_pkg::NUM_SUMS];
  ewca_pkg::energy_t       peak_energy;
  ewca_pkg::pid_t          peak_id;
  ewca_pkg::esum_t         tdc_energy_sum;
  ewca_pkg::energy_t       tdc_peak_energy;
  ewca_pkg::word_t         tdc_peak_time;
  ewca_pkg::count_t        tdc_block_count;

  ewca_pkg::word_t         mac_operand;
  ewca_pkg::wsum_t         mac_sum;
  ewca_pkg::esum_t         div_den;
  logic                    div_done;
  ewca_pkg::word_t         div_mean;

  function automatic ewca_pkg::esum_t esat(ewca_pkg::esum_t a, ewca_pkg::energy_t b);
    logic [ewca_pkg::ESUM_W:0] s;
    s = {1'b0, a} + (ewca_pkg::ESUM_W + 1)'(b);
    return s[ewca_pkg::ESUM_W] ? ewca_pkg::ESUM_MAX : s[ewca_pkg::ESUM_W-1:0];
  endfunction

  assign cap       = (max_elements < ewca_pkg::CAP_LIMIT) ? max_elements
                                                           : ewca_pkg::CAP_LIMIT;
  assign last_sel  = blk_has_tdc ? ewca_pkg::SUM_WALK : ewca_pkg::SUM_ADC;
  assign hit.ready = (state == S_IDLE);

  always_comb begin
    case (sel)
      ewca_pkg::SUM_X:   mac_operand = blk_x;
      ewca_pkg::SUM_Y:   mac_operand = blk_y;
      ewca_pkg::SUM_ADC: mac_operand = blk_adc;
      ewca_pkg::SUM_TDC: mac_operand = blk_tdc;
      default:           mac_operand = blk_walk;
    endcase
  end

  // x, y and ADC means use the full energy sum, the TDC means the TDC one
  assign div_den = (sel > ewca_pkg::SUM_ADC) ? tdc_energy_sum : energy_sum;

  ewca_mac u_mac (
    .clk     (clk),
    .mul_en  (state == S_MUL),
    .energy  (blk_e),
    .operand (mac_operand),
    .acc     (wsum[sel]),
    .sum     (mac_sum)
  );

  ewca_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV_GO),
    .sum   (wsum[sel]),
    .den   (div_den),
    .done  (div_done),
    .mean  (div_mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_elements <= ewca_pkg::CNT_W'(9);
    end else if (cfg_we) begin
      max_elements <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sel             <= '0;
      accepted        <= 1'b0;
      summary.valid   <= 1'b0;
      block_count     <= '0;
      energy_sum      <= '0;
      peak_energy     <= '0;
      peak_id         <= ewca_pkg::PEAK_ID_NONE;
      tdc_energy_sum  <= '0;
      tdc_peak_energy <= '0;
      tdc_peak_time   <= '0;
      tdc_block_count <= '0;
      for (int i = 0; i < ewca_pkg::NUM_SUMS; i++) begin
        wsum[i] <= '0;
        mean[i] <= '0;
      end
    end else begin
      // in S_FINISH the load below decides valid
      if (summary.valid && summary.ready && (state != S_FINISH)) begin
        summary.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (hit.valid) begin
            blk_e       <= hit.block_energy & ewca_pkg::ENERGY_MASK;
            blk_x       <= hit.block_x;
            blk_y       <= hit.block_y;
            blk_adc     <= hit.adc_time;
            blk_id      <= hit.element_id;
            blk_has_tdc <= hit.has_tdc;
            blk_tdc     <= hit.tdc_time;
            blk_walk    <= hit.tdc_time_walk;
            sel         <= '0;
            if (hit.opcode == ewca_pkg::OP_CLEAR) begin
              accepted        <= 1'b0;
              block_count     <= '0;
              energy_sum      <= '0;
              peak_energy     <= '0;
              peak_id         <= ewca_pkg::PEAK_ID_NONE;
              tdc_energy_sum  <= '0;
              tdc_peak_energy <= '0;
              tdc_peak_time   <= '0;
              tdc_block_count <= '0;
              for (int i = 0; i < ewca_pkg::NUM_SUMS; i++) begin
                wsum[i] <= '0;
                mean[i] <= '0;
              end
              state <= S_FINISH;
            end else if (block_count < cap) begin
              accepted <= 1'b1;
              state    <= S_ACC;
            end else begin
              accepted <= 1'b0;
              state    <= S_FINISH;
            end
          end
        end

        S_ACC: begin
          block_count <= block_count + 1'b1;
          energy_sum  <= esat(energy_sum, blk_e);
          if (blk_e > peak_energy) begin
            peak_energy <= blk_e;
            peak_id     <= ewca_pkg::PID_W'(blk_id);
          end
          if (blk_has_tdc) begin
            tdc_energy_sum  <= esat(tdc_energy_sum, blk_e);
            tdc_block_count <= tdc_block_count + 1'b1;
            if (blk_e > tdc_peak_energy) begin
              tdc_peak_energy <= blk_e;
              tdc_peak_time   <= blk_tdc;
            end
          end
          state <= S_MUL;
        end

        S_MUL: begin
          state <= S_ADD;
        end

        S_ADD: begin
          wsum[sel] <= mac_sum;
          if (sel == last_sel) begin
            sel   <= '0;
            state <= S_DIV_GO;
          end else begin
            sel   <= sel + 1'b1;
            state <= S_MUL;
          end
        end

        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_done) begin
            mean[sel] <= div_mean;
            if (sel == last_sel) begin
              state <= S_FINISH;
            end else begin
              sel   <= sel + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end

        S_FINISH: begin
          if (!summary.valid || summary.ready) begin
            summary.valid            <= 1'b1;
            summary.accepted         <= accepted;
            summary.multiplicity     <= block_count;
            summary.energy_total     <= energy_sum;
            summary.max_block_energy <= peak_energy;
            summary.max_block_id     <= peak_id;
            summary.centroid_x       <= mean[ewca_pkg::SUM_X];
            summary.centroid_y       <= mean[ewca_pkg::SUM_Y];
            summary.adc_time_mean    <= mean[ewca_pkg::SUM_ADC];
            summary.tdc_time_mean    <= mean[ewca_pkg::SUM_TDC];
            summary.tdc_walk_mean    <= mean[ewca_pkg::SUM_WALK];
            summary.tdc_time_of_max  <= tdc_peak_time;
            summary.good_tdc_count   <= tdc_block_count;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_count_within_cap: assert property (@(posedge clk) disable iff (rst)
    block_count <= ewca_pkg::CAP_LIMIT)
    else $error("multiplicity beyond the cap");

  a_tdc_count_bounded: assert property (@(posedge clk) disable iff (rst)
    tdc_block_count <= block_count)
    else $error("TDC block count exceeds multiplicity");

  a_finish_loads_summary: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && (!summary.valid || summary.ready) |=>
      summary.valid && (state == S_IDLE))
    else $error("finished item not loaded into the summary register");

endmodule
